>>> rtl/bhbt_pkg.sv
package bhbt_pkg;

   // Word store behind the heap; handles are 16 bits wide.
   localparam int unsigned STORE_DEPTH   = 65536;
   localparam int unsigned MEM_WORDS_DEF = 65536;

   // Boundary tag layout: capacity and flag ahead of the data, footer after it.
   localparam int unsigned HDR_WORDS = 2;
   localparam int unsigned FTR_WORDS = 1;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_FREE  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_OOM     = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC,
      S_FLAG,
      S_CAP,
      S_FOOT,
      S_DATA,
      S_DONE
   } state_type;

endpackage

>>> rtl/bump_heap_with_boundary_tags.sv
// Bump heap with boundary tags.
// A request arrives on the req_ channel (valid/ready) and carries an opcode:
// allocate, read word, write word or free block. Every request produces
// exactly one response on the rsp_ channel (valid/ready) with a status, the
// new handle of an allocate, the word of a read and the block capacity.
// Requests are processed one at a time; req_ready is high only while the
// sequencer is idle. A free, a handle outside the used region and an
// out-of-memory allocate end early; an allocate writes its block one
// store word per cycle. The word store reads through a register, so an
// access walks flag, capacity, footer and data in turn, and a cleared flag
// or broken tags end the request early. The next request is taken in the
// cycle after the response is loaded. The response sits in an output
// register, so a new request is accepted while an earlier response still
// waits for rsp_ready. When the receiver stalls, a finished request waits
// in the done state until the output register frees up, and no further
// request is accepted meanwhile.
// Synchronous reset empties the heap by clearing the bump pointer and drops
// any pending response. The store itself is not cleared: only words below
// the bump pointer are ever read, and an allocate writes all of those.
module bump_heap_with_boundary_tags #(
   parameter int unsigned MEM_WORDS = bhbt_pkg::MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_block_handle,
   input  logic [15:0] req_word_offset,
   input  logic [15:0] req_request_words,
   input  logic [31:0] req_write_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_new_handle,
   output logic [31:0] rsp_read_word,
   output logic [15:0] rsp_block_words
);

   // The usable heap is the smaller of MEM_WORDS and the 16-bit handle space.
   localparam int unsigned DEPTH = (MEM_WORDS < bhbt_pkg::STORE_DEPTH) ?
                                   MEM_WORDS : bhbt_pkg::STORE_DEPTH;
   localparam int unsigned AW = $clog2(DEPTH);
   // The bump pointer must be able to hold DEPTH itself.
   localparam int unsigned PW = $clog2(DEPTH + 1);

   bhbt_pkg::state_type state_ff, state_in;

   logic [PW-1:0] bump_ff, bump_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Captured request and working registers.
   logic [1:0]    op_ff, op_in;
   logic [15:0]   handle_ff, handle_in;
   logic [15:0]   offset_ff, offset_in;
   logic [15:0]   words_ff, words_in;
   logic [31:0]   wdata_ff, wdata_in;
   logic [31:0]   cap_ff, cap_in;
   logic [PW-1:0] addr_ff, addr_in;
   logic [PW-1:0] end_ff, end_in;

   // Result being built for the current request.
   logic [1:0]    res_status_ff, res_status_in;
   logic [15:0]   res_handle_ff, res_handle_in;
   logic [31:0]   res_read_ff, res_read_in;
   logic [15:0]   res_words_ff, res_words_in;

   // Output register.
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_handle_ff, rsp_handle_in;
   logic [31:0]   rsp_read_ff, rsp_read_in;
   logic [15:0]   rsp_words_ff, rsp_words_in;

   // Word store.
   logic [31:0]   heap_mem [DEPTH];
   logic [31:0]   mem_rdata_ff;
   logic [AW-1:0] mem_raddr;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic          mem_we;

   logic [17:0]   alloc_end;
   logic          alloc_oom;
   logic          handle_ok;
   logic [32:0]   foot_addr;
   logic          foot_ok;
   logic          offset_ok;
   logic [15:0]   data_addr;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= heap_mem[mem_raddr];
   end

   // The new block ends at bump + header + data + footer; that end must stay
   // inside the usable heap.
   assign alloc_end = 18'(bump_ff) + 18'(req_request_words)
                    + 18'(bhbt_pkg::HDR_WORDS + bhbt_pkg::FTR_WORDS);
   assign alloc_oom = alloc_end > 18'(DEPTH);

   // A handle must point past the header of the first block and stay inside
   // the used region.
   assign handle_ok = (req_block_handle >= 16'(bhbt_pkg::HDR_WORDS)) &&
                      (17'(req_block_handle) < 17'(bump_ff));

   // The capacity word arrives in the capacity step; the footer must sit below
   // the bump pointer and the offset must fall inside the capacity.
   assign foot_addr = 33'(handle_ff) + 33'(mem_rdata_ff);
   assign foot_ok   = foot_addr < 33'(bump_ff);
   assign offset_ok = 32'(offset_ff) < mem_rdata_ff;
   assign data_addr = handle_ff + offset_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      bump_in       = bump_ff;
      op_in         = op_ff;
      handle_in     = handle_ff;
      offset_in     = offset_ff;
      words_in      = words_ff;
      wdata_in      = wdata_ff;
      cap_in        = cap_ff;
      addr_in       = addr_ff;
      end_in        = end_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_read_in   = res_read_ff;
      res_words_in  = res_words_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_words_in  = rsp_words_ff;
      mem_raddr     = '0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_we        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bhbt_pkg::S_IDLE: begin
            mem_raddr = AW'(req_block_handle - 16'd1);
            if (req_valid) begin
               op_in         = req_op;
               handle_in     = req_block_handle;
               offset_in     = req_word_offset;
               words_in      = req_request_words;
               wdata_in      = req_write_word;
               res_status_in = bhbt_pkg::ST_INVALID;
               res_handle_in = '0;
               res_read_in   = '0;
               res_words_in  = '0;
               if (req_op == bhbt_pkg::OP_ALLOC) begin
                  if (alloc_oom) begin
                     res_status_in = bhbt_pkg::ST_OOM;
                     state_in      = bhbt_pkg::S_DONE;
                  end else begin
                     addr_in  = bump_ff;
                     end_in   = PW'(alloc_end);
                     state_in = bhbt_pkg::S_ALLOC;
                  end
               end else if (handle_ok) begin
                  // The flag word read is already on its way.
                  state_in = bhbt_pkg::S_FLAG;
               end else begin
                  state_in = bhbt_pkg::S_DONE;
               end
            end
         end

         bhbt_pkg::S_ALLOC: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(addr_ff);
            if (addr_ff == bump_ff) begin
               mem_wdata = 32'(words_ff);
            end else if (addr_ff == bump_ff + PW'(1)) begin
               mem_wdata = 32'd1;
            end else if (addr_ff == end_ff - PW'(1)) begin
               mem_wdata = 32'(words_ff);
            end else begin
               mem_wdata = '0;
            end
            addr_in = addr_ff + PW'(1);
            if (addr_ff == end_ff - PW'(1)) begin
               bump_in       = end_ff;
               res_status_in = bhbt_pkg::ST_OK;
               res_handle_in = 16'(bump_ff + PW'(bhbt_pkg::HDR_WORDS));
               state_in      = bhbt_pkg::S_DONE;
            end
         end

         bhbt_pkg::S_FLAG: begin
            mem_raddr = AW'(handle_ff - 16'd2);
            if (mem_rdata_ff == '0) begin
               state_in = bhbt_pkg::S_DONE;
            end else if (op_ff == bhbt_pkg::OP_FREE) begin
               mem_we        = 1'b1;
               mem_waddr     = AW'(handle_ff - 16'd1);
               mem_wdata     = '0;
               res_status_in = bhbt_pkg::ST_OK;
               state_in      = bhbt_pkg::S_DONE;
            end else begin
               state_in = bhbt_pkg::S_CAP;
            end
         end

         bhbt_pkg::S_CAP: begin
            mem_raddr = AW'(foot_addr);
            cap_in    = mem_rdata_ff;
            if (foot_ok && offset_ok) begin
               state_in = bhbt_pkg::S_FOOT;
            end else begin
               state_in = bhbt_pkg::S_DONE;
            end
         end

         bhbt_pkg::S_FOOT: begin
            mem_raddr = AW'(data_addr);
            if (mem_rdata_ff != cap_ff) begin
               state_in = bhbt_pkg::S_DONE;
            end else if (op_ff == bhbt_pkg::OP_READ) begin
               state_in = bhbt_pkg::S_DATA;
            end else begin
               mem_we        = 1'b1;
               mem_waddr     = AW'(data_addr);
               mem_wdata     = wdata_ff;
               res_status_in = bhbt_pkg::ST_OK;
               res_words_in  = 16'(cap_ff);
               state_in      = bhbt_pkg::S_DONE;
            end
         end

         bhbt_pkg::S_DATA: begin
            res_status_in = bhbt_pkg::ST_OK;
            res_read_in   = mem_rdata_ff;
            res_words_in  = 16'(cap_ff);
            state_in      = bhbt_pkg::S_DONE;
         end

         bhbt_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_read_in   = res_read_ff;
               rsp_words_in  = res_words_ff;
               state_in      = bhbt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bhbt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bhbt_pkg::S_IDLE;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      offset_ff     <= offset_in;
      words_ff      <= words_in;
      wdata_ff      <= wdata_in;
      cap_ff        <= cap_in;
      addr_ff       <= addr_in;
      end_ff        <= end_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_read_ff   <= res_read_in;
      res_words_ff  <= res_words_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_words_ff  <= rsp_words_in;
   end

   assign req_ready       = (state_ff == bhbt_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_new_handle  = rsp_handle_ff;
   assign rsp_read_word   = rsp_read_ff;
   assign rsp_block_words = rsp_words_ff;

endmodule

>>> rtl/bhbt_checker.sv
module bhbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_op,
   input logic [15:0] req_block_handle,
   input logic [15:0] req_word_offset,
   input logic [15:0] req_request_words,
   input logic [31:0] req_write_word,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_new_handle,
   input logic [31:0] rsp_read_word,
   input logic [15:0] rsp_block_words
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_new_handle) && $stable(rsp_read_word) && $stable(rsp_block_words))
      else $error("response changed while stalled");

   // Requests are processed one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   // Reset drops any pending response.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A failed request returns zeros in all data fields.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bhbt_pkg::ST_OK |->
      rsp_new_handle == 16'd0 && rsp_read_word == 32'd0 && rsp_block_words == 16'd0)
      else $error("failed response carries data");

   // A successful allocate returns a handle past the header and nothing else.
   a_alloc_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bhbt_pkg::ST_OK && rsp_new_handle != 16'd0 |->
      rsp_new_handle >= 16'd2 && rsp_read_word == 32'd0 && rsp_block_words == 16'd0)
      else $error("malformed allocate response");

endmodule

bind bump_heap_with_boundary_tags bhbt_checker u_bhbt_checker (.*);

>>> bench/heap_reply_check.sv
module heap_reply_check #(
   parameter int unsigned MEM_WORDS = bhbt_pkg::MEM_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_block_handle,
   input  logic [15:0] req_word_offset,
   input  logic [15:0] req_request_words,
   input  logic [31:0] req_write_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_new_handle,
   input  logic [31:0] rsp_read_word,
   input  logic [15:0] rsp_block_words,
   output int          failures,
   output int          pending_results,
   output logic [16:0] used_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] new_handle;
      logic [31:0] read_word;
      logic [15:0] block_words;
   } heap_reply_type;

   localparam int unsigned HEAP_LIMIT = (MEM_WORDS < bhbt_pkg::STORE_DEPTH) ?
                                        MEM_WORDS : bhbt_pkg::STORE_DEPTH;

   logic [31:0]    heap_words [0:bhbt_pkg::STORE_DEPTH-1];
   logic [16:0]    heap_top;
   heap_reply_type replies_due[$];
   heap_reply_type reply_seen;
   heap_reply_type reply_due;

   // A handle is live when it lies in the used region and its flag word is nonzero.
   function automatic logic block_live(input logic [15:0] handle);
      return (handle >= bhbt_pkg::HDR_WORDS) && ({1'b0, handle} < heap_top) &&
             (heap_words[handle - 16'd1] != 32'd0);
   endfunction

   function automatic string reply_text(input heap_reply_type r);
      return $sformatf("status %0d handle %0d word %h words %0d",
                       r.status, r.new_handle, r.read_word, r.block_words);
   endfunction

   function automatic heap_reply_type predict_heap_reply(input logic [1:0] op,
                                                         input logic [15:0] handle,
                                                         input logic [15:0] offset,
                                                         input logic [15:0] words,
                                                         input logic [31:0] data);
      heap_reply_type reply;
      logic [31:0] base;
      logic [31:0] stop;
      logic [31:0] cap;
      logic [32:0] foot_addr;
      reply = '0;
      reply.status = bhbt_pkg::ST_INVALID;
      if (op == bhbt_pkg::OP_ALLOC) begin
         base = {15'd0, heap_top} + bhbt_pkg::HDR_WORDS;
         stop = base + {16'd0, words} + bhbt_pkg::FTR_WORDS;
         if (stop > HEAP_LIMIT) begin
            reply.status = bhbt_pkg::ST_OOM;
         end else begin
            heap_words[base - 2] = {16'd0, words};
            heap_words[base - 1] = 32'd1;
            for (int i = 0; i < words; i++)
               heap_words[base + i] = 32'd0;
            heap_words[base + words] = {16'd0, words};
            heap_top = stop[16:0];
            reply.status = bhbt_pkg::ST_OK;
            reply.new_handle = base[15:0];
         end
      end else if (op == bhbt_pkg::OP_FREE) begin
         if (block_live(handle)) begin
            heap_words[handle - 16'd1] = 32'd0;
            reply.status = bhbt_pkg::ST_OK;
         end
      end else if (block_live(handle)) begin
         cap = heap_words[handle - 16'd2];
         foot_addr = {17'd0, handle} + {1'b0, cap};
         if (foot_addr < {16'd0, heap_top} && heap_words[foot_addr[15:0]] == cap &&
             {16'd0, offset} < cap) begin
            reply.status = bhbt_pkg::ST_OK;
            reply.block_words = cap[15:0];
            if (op == bhbt_pkg::OP_READ)
               reply.read_word = heap_words[handle + offset];
            else
               heap_words[handle + offset] = data;
         end
      end
      return reply;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         heap_top = '0;
         replies_due.delete();
         failures = 0;
      end else begin
         // A response always belongs to an older request, so it is retired first.
         if (rsp_valid && rsp_ready) begin
            reply_seen = {rsp_status, rsp_new_handle, rsp_read_word, rsp_block_words};
            if (replies_due.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: response with none pending: %s",
                           $realtime, reply_text(reply_seen));
            end else begin
               reply_due = replies_due.pop_front();
               if (reply_seen !== reply_due) begin
                  failures++;
                  if (failures <= 10)
                     $display("%0t: expected %s, got %s", $realtime,
                              reply_text(reply_due), reply_text(reply_seen));
               end
            end
         end
         if (req_valid && req_ready)
            replies_due.push_back(predict_heap_reply(req_op, req_block_handle,
                                                     req_word_offset, req_request_words,
                                                     req_write_word));
      end
      pending_results <= replies_due.size();
      used_words <= heap_top;
   end

endmodule

>>> bench/bump_heap_with_boundary_tags_test.sv
module bump_heap_with_boundary_tags_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HEAP_WORDS = bhbt_pkg::MEM_WORDS_DEF;
   localparam int unsigned HEAP_LIMIT = (HEAP_WORDS < bhbt_pkg::STORE_DEPTH) ?
                                        HEAP_WORDS : bhbt_pkg::STORE_DEPTH;
   localparam int unsigned MAX_REQUEST = 65533;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_REQUESTS = 950;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = bhbt_pkg::OP_ALLOC;
   logic [15:0] req_block_handle = '0;
   logic [15:0] req_word_offset = '0;
   logic [15:0] req_request_words = '0;
   logic [31:0] req_write_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_new_handle;
   logic [31:0] rsp_read_word;
   logic [15:0] rsp_block_words;

   int          failures;
   int          pending_results;
   logic [16:0] used_words;

   // Stimulus bookkeeping. The lists only steer the random part toward handles
   // that should be live; the checker alone decides what the block must answer.
   logic [15:0] live_handle[$];
   logic [15:0] live_cap[$];
   logic [15:0] freed_handle[$];
   int          send_count = 0;
   logic        send_burst = 1'b0;
   int          rsp_count = 0;
   logic        rsp_burst = 1'b0;
   int          rsp_hold = 0;
   logic        rsp_taken = 1'b0;
   int          cycle_count = 0;

   logic [1:0]  op;
   logic [15:0] handle;
   logic [15:0] offset;
   logic [15:0] words;
   logic [31:0] data;
   int unsigned pick;
   int unsigned sel;
   int unsigned slot;
   int unsigned lo;

   bump_heap_with_boundary_tags #(.MEM_WORDS(HEAP_WORDS)) uut (.*);

   heap_reply_check #(.MEM_WORDS(HEAP_WORDS)) reply_check (.*);

   always #5 clock = ~clock;

   // Random 16-bit filler for fields that a request does not use.
   function automatic logic [15:0] rand_half();
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] rand_words();
      return 16'($urandom_range(0, MAX_REQUEST));
   endfunction

   // The run is bounded by a cycle count well above the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // The receiver draws a stall for every response. The stall only counts down
   // while a response is actually waiting, so the gap lands on the response itself.
   // Now and then a stretch of responses is taken with no stall at all.
   always @(posedge clock) rsp_taken <= rsp_valid && rsp_ready;

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_count++;
         if (rsp_count % 64 == 0)
            rsp_burst = ($urandom_range(0, 3) == 0);
         rsp_hold = rsp_burst ? 0 : $urandom_range(0, 17);
      end
      rsp_ready <= (rsp_hold == 0);
      if (rsp_valid && rsp_hold != 0)
         rsp_hold--;
   end

   // Sends one request. It is entered at a falling edge and returns at the
   // falling edge after the request was taken, with valid still high, so a
   // request with no gap follows without valid ever dropping.
   task automatic send_request(input logic [1:0] r_op, input logic [15:0] r_handle,
                               input logic [15:0] r_offset, input logic [15:0] r_words,
                               input logic [31:0] r_data);
      int gap;
      send_count++;
      if (send_count % 64 == 0)
         send_burst = ($urandom_range(0, 3) == 0);
      gap = send_burst ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op <= r_op;
      req_block_handle <= r_handle;
      req_word_offset <= r_offset;
      req_request_words <= r_words;
      req_write_word <= r_data;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Holds the sender off until every response has come back. It returns at a
   // falling edge after valid was lowered, so the next request raises it anew.
   task automatic drain_heap();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The heap starts empty, so every handle below is known.
      // Accesses to an empty heap are rejected, at both ends of the handle range.
      send_request(bhbt_pkg::OP_READ, 16'd0, 16'd0, rand_words(), $urandom);
      send_request(bhbt_pkg::OP_FREE, 16'd1, rand_half(), rand_words(), $urandom);
      send_request(bhbt_pkg::OP_WRITE, 16'hFFFF, 16'd0, rand_words(), 32'hFFFF_FFFF);
      // An empty block at handle 2 has no valid offset at all.
      send_request(bhbt_pkg::OP_ALLOC, rand_half(), rand_half(), 16'd0, $urandom);
      send_request(bhbt_pkg::OP_READ, 16'd2, 16'd0, rand_words(), $urandom);
      // A four word block at handle 5: fresh data reads as zero, the last offset
      // holds a written word, and offsets at or past the capacity are rejected.
      send_request(bhbt_pkg::OP_ALLOC, rand_half(), rand_half(), 16'd4, $urandom);
      send_request(bhbt_pkg::OP_WRITE, 16'd5, 16'd3, rand_words(), 32'hFFFF_FFFF);
      send_request(bhbt_pkg::OP_READ, 16'd5, 16'd3, rand_words(), $urandom);
      send_request(bhbt_pkg::OP_READ, 16'd5, 16'd0, rand_words(), $urandom);
      send_request(bhbt_pkg::OP_READ, 16'd5, 16'd4, rand_words(), $urandom);
      send_request(bhbt_pkg::OP_WRITE, 16'd5, 16'hFFFF, rand_words(), 32'd0);
      // A handle equal to the bump pointer lies just outside the used region.
      send_request(bhbt_pkg::OP_READ, 16'd10, 16'd0, rand_words(), $urandom);
      // The largest request cannot fit once anything is allocated.
      send_request(bhbt_pkg::OP_ALLOC, rand_half(), rand_half(), 16'(MAX_REQUEST), $urandom);
      // Block at handle 12 with eight words. Its first words form a fake header
      // for handle 14: capacity 3, flag 1, and a footer that is wrong at first.
      send_request(bhbt_pkg::OP_ALLOC, rand_half(), rand_half(), 16'd8, $urandom);
      send_request(bhbt_pkg::OP_WRITE, 16'd12, 16'd0, rand_words(), 32'd3);
      send_request(bhbt_pkg::OP_WRITE, 16'd12, 16'd1, rand_words(), 32'd1);
      send_request(bhbt_pkg::OP_READ, 16'd14, 16'd0, rand_words(), $urandom);
      // With a matching footer the fake block becomes fully accessible.
      send_request(bhbt_pkg::OP_WRITE, 16'd12, 16'd5, rand_words(), 32'd3);
      send_request(bhbt_pkg::OP_WRITE, 16'd12, 16'd4, rand_words(), 32'h5A5A_A5A5);
      send_request(bhbt_pkg::OP_READ, 16'd14, 16'd2, rand_words(), $urandom);
      // A huge capacity puts the footer past the bump pointer, which breaks the
      // tags for an access, while free looks only at the flag and succeeds.
      send_request(bhbt_pkg::OP_WRITE, 16'd12, 16'd0, rand_words(), 32'hFFFF_FFFF);
      send_request(bhbt_pkg::OP_READ, 16'd14, 16'd0, rand_words(), $urandom);
      send_request(bhbt_pkg::OP_FREE, 16'd14, rand_half(), rand_words(), $urandom);
      // Free, double free, and an access to the freed block.
      send_request(bhbt_pkg::OP_FREE, 16'd5, rand_half(), rand_words(), $urandom);
      send_request(bhbt_pkg::OP_FREE, 16'd5, rand_half(), rand_words(), $urandom);
      send_request(bhbt_pkg::OP_READ, 16'd5, 16'd0, rand_words(), $urandom);
      live_handle.push_back(16'd2);
      live_cap.push_back(16'd0);
      live_handle.push_back(16'd12);
      live_cap.push_back(16'd8);
      freed_handle.push_back(16'd5);
      drain_heap();

      // Random part. Most requests follow the life of real blocks: allocate,
      // access in range, free. The rest are stray handles, freed handles and
      // wild offsets, plus allocations sized to run out of memory.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 300 || n == 650)
            drain_heap();
         handle = rand_half();
         offset = rand_half();
         words = rand_words();
         data = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            op = bhbt_pkg::OP_ALLOC;
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
               words = 16'($urandom_range(0, 15));
            end else if (sel < 93) begin
               words = 16'($urandom_range(16, 255));
            end else begin
               // Smallest request that no longer fits, up to the largest legal one.
               lo = HEAP_LIMIT - 2 - 32'(used_words);
               if (lo > MAX_REQUEST)
                  lo = MAX_REQUEST;
               words = 16'($urandom_range(MAX_REQUEST, lo));
            end
            if (32'(used_words) + bhbt_pkg::HDR_WORDS + 32'(words) + bhbt_pkg::FTR_WORDS
                <= HEAP_LIMIT) begin
               live_handle.push_back(16'(used_words + bhbt_pkg::HDR_WORDS));
               live_cap.push_back(words);
            end
         end else if (pick < 85) begin
            op = (pick < 55) ? bhbt_pkg::OP_WRITE : bhbt_pkg::OP_READ;
            if (live_handle.size() != 0 && $urandom_range(0, 4) != 0) begin
               slot = $urandom_range(0, live_handle.size() - 1);
               handle = live_handle[slot];
               if (live_cap[slot] == 0 || $urandom_range(0, 9) == 0)
                  offset = live_cap[slot];
               else
                  offset = 16'($urandom_range(0, live_cap[slot] - 1));
            end else begin
               // Handles inside the used region read data words as tags, which
               // is where fake and broken boundary tags show up.
               sel = $urandom_range(0, 3);
               if (sel < 2)
                  handle = 16'($urandom_range(0, used_words + 3));
               else if (sel == 2 && freed_handle.size() != 0)
                  handle = freed_handle[$urandom_range(0, freed_handle.size() - 1)];
               if ($urandom_range(0, 1) == 0)
                  offset = 16'($urandom_range(0, 15));
            end
            // Small words written into data often look like capacities and flags.
            if ($urandom_range(0, 2) == 0)
               data = $urandom_range(0, 20);
         end else begin
            op = bhbt_pkg::OP_FREE;
            if (live_handle.size() != 0 && $urandom_range(0, 9) < 7) begin
               slot = $urandom_range(0, live_handle.size() - 1);
               handle = live_handle[slot];
               freed_handle.push_back(handle);
               live_handle.delete(slot);
               live_cap.delete(slot);
            end else if (freed_handle.size() != 0 && $urandom_range(0, 1) == 0) begin
               handle = freed_handle[$urandom_range(0, freed_handle.size() - 1)];
            end else begin
               handle = 16'($urandom_range(0, used_words + 3));
            end
         end
         send_request(op, handle, offset, words, data);
      end

      // Fill the heap exactly to its end, so the last footer sits in the top
      // word, then show that nothing more fits and the last block still works.
      if (used_words + bhbt_pkg::HDR_WORDS + bhbt_pkg::FTR_WORDS <= HEAP_LIMIT) begin
         words = 16'(HEAP_LIMIT - bhbt_pkg::HDR_WORDS - bhbt_pkg::FTR_WORDS - used_words);
         handle = 16'(used_words + bhbt_pkg::HDR_WORDS);
         send_request(bhbt_pkg::OP_ALLOC, rand_half(), rand_half(), words, $urandom);
         send_request(bhbt_pkg::OP_ALLOC, rand_half(), rand_half(), 16'd0, $urandom);
         if (words != 0) begin
            send_request(bhbt_pkg::OP_WRITE, handle, words - 16'd1, rand_words(),
                         32'hFFFF_FFFF);
            send_request(bhbt_pkg::OP_READ, handle, words - 16'd1, rand_words(), $urandom);
         end
         send_request(bhbt_pkg::OP_READ, handle, words, rand_words(), $urandom);
         send_request(bhbt_pkg::OP_READ, 16'hFFFF, 16'hFFFF, rand_words(), $urandom);
         send_request(bhbt_pkg::OP_FREE, handle, rand_half(), rand_words(), $urandom);
      end

      // Let every response come back, then wait out SETTLE_CYCLES so that the block
      // can show any response that should not be there.
      drain_heap();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
